/* rtl/lof_pkg.sv */
// ----------------------------------------------------------------------------
// lof_pkg: shared types and constants of the loose octree cell finder
// Box and result payloads, configuration set, register indexes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lof_pkg;

  localparam int COORD_BITS = 24;
  localparam int MAX_LEVELS = 12;
  localparam int LEVEL_W    = 4;
  localparam int CELL_W     = 12;
  localparam int DEPTH_W    = 4;
  localparam int REG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CUBE_LOW_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CUBE_LOW_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUBE_LOW_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CUBE_SIZE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DEPTH  = 3'd4;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_low_x;
    logic signed [COORD_BITS-1:0] box_low_y;
    logic signed [COORD_BITS-1:0] box_low_z;
    logic signed [COORD_BITS-1:0] box_high_x;
    logic signed [COORD_BITS-1:0] box_high_y;
    logic signed [COORD_BITS-1:0] box_high_z;
  } box_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [CELL_W-1:0]  cell_z;
    logic               outside;
  } cell_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cube_low_x;
    logic signed [COORD_BITS-1:0] cube_low_y;
    logic signed [COORD_BITS-1:0] cube_low_z;
    logic [COORD_BITS-1:0]        cube_size;
    logic [DEPTH_W-1:0]           max_depth;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       search;
    logic       set_level;
    logic       div_init;
    logic       div_step;
    logic       store;
    logic       commit;
    logic [1:0] axis;
  } lof_cmd_t;

  typedef struct packed {
    logic search_last;
    logic div_done;
    logic out_free;
  } lof_status_t;

endpackage

/* rtl/lof_datapath.sv */
// ----------------------------------------------------------------------------
// lof_datapath: level search, shared restoring divider and result register
// Holds the captured box terms, iterates the level test one step a cycle,
// divides one axis at a time and keeps the finished result for transfer.
// ----------------------------------------------------------------------------
module lof_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lof_pkg::lof_cmd_t   cmd,
  output lof_pkg::lof_status_t status,
  input  lof_pkg::box_t       in_data,
  input  lof_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output lof_pkg::cell_t      out_data
);
  import lof_pkg::*;

  localparam int EXT_W = COORD_BITS + 1;            // box extent
  localparam int C2_W  = COORD_BITS + 3;            // twice center offset
  localparam int DV_W  = COORD_BITS + 1;            // divisor 2 * size
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int KW    = $clog2(MAX_LEVELS + 2);
  localparam int QW    = MAX_LEVELS;

  logic signed [EXT_W-1:0] dx, dy, dz, e_max;
  logic signed [C2_W-1:0]  c2_in [3];
  logic [COORD_BITS-1:0]   size_eff;
  logic [DV_W-1:0]         dvs_in;

  logic [DV_W-1:0]         dvs;
  logic [DV_W:0]           t_sh;
  logic                    e_nonpos;
  logic [KW-1:0]           k;
  logic [KW-1:0]           best;
  logic [LW-1:0]           lim;
  logic [LW-1:0]           lvl;
  logic signed [C2_W-1:0]  c2 [3];
  logic [DV_W-1:0]         rem;
  logic [QW-1:0]           q;
  logic [LW-1:0]           cnt;
  logic                    neg;
  logic                    over;
  logic [CELL_W-1:0]       cell_idx [3];
  logic                    outside_acc;

  logic                    pass;
  logic [LW-1:0]           lvl_raw;
  logic [LW-1:0]           lvl_next;
  logic [LW-1:0]           lim_in;
  logic [DV_W:0]           rem2;
  logic                    fit;
  logic [QW-1:0]           top;
  logic signed [C2_W-1:0]  c2_sel;

  always_comb begin
    dx = {in_data.box_high_x[COORD_BITS-1], in_data.box_high_x}
       - {in_data.box_low_x[COORD_BITS-1], in_data.box_low_x};
    dy = {in_data.box_high_y[COORD_BITS-1], in_data.box_high_y}
       - {in_data.box_low_y[COORD_BITS-1], in_data.box_low_y};
    dz = {in_data.box_high_z[COORD_BITS-1], in_data.box_high_z}
       - {in_data.box_low_z[COORD_BITS-1], in_data.box_low_z};
    e_max = dx;
    if (dy > e_max) e_max = dy;
    if (dz > e_max) e_max = dz;

    c2_in[0] = {{3{in_data.box_low_x[COORD_BITS-1]}}, in_data.box_low_x}
             + {{3{in_data.box_high_x[COORD_BITS-1]}}, in_data.box_high_x}
             - {{2{cfg.cube_low_x[COORD_BITS-1]}}, cfg.cube_low_x, 1'b0};
    c2_in[1] = {{3{in_data.box_low_y[COORD_BITS-1]}}, in_data.box_low_y}
             + {{3{in_data.box_high_y[COORD_BITS-1]}}, in_data.box_high_y}
             - {{2{cfg.cube_low_y[COORD_BITS-1]}}, cfg.cube_low_y, 1'b0};
    c2_in[2] = {{3{in_data.box_low_z[COORD_BITS-1]}}, in_data.box_low_z}
             + {{3{in_data.box_high_z[COORD_BITS-1]}}, in_data.box_high_z}
             - {{2{cfg.cube_low_z[COORD_BITS-1]}}, cfg.cube_low_z, 1'b0};

    // a zero cube size counts as one unit
    size_eff = (cfg.cube_size == '0) ? COORD_BITS'(1) : cfg.cube_size;
    dvs_in   = {size_eff, 1'b0};

    if (32'(cfg.max_depth) > MAX_LEVELS) lim_in = LW'(MAX_LEVELS);
    else                                 lim_in = LW'(cfg.max_depth);
  end

  // level test: 2 * size >= e << k
  assign pass = (t_sh <= {1'b0, dvs});
  assign status.search_last = e_nonpos || !pass || (k == KW'(MAX_LEVELS + 1));

  always_comb begin
    if (e_nonpos)         lvl_raw = LW'(MAX_LEVELS);
    else if (best == '0)  lvl_raw = '0;
    else                  lvl_raw = LW'(best - KW'(1));
    lvl_next = (lvl_raw > lim) ? lim : lvl_raw;
  end

  // restoring divider step
  assign rem2 = {rem, 1'b0};
  assign fit  = (rem2 >= {1'b0, dvs});
  assign top  = ~({QW{1'b1}} << lvl);
  assign c2_sel = c2[cmd.axis];
  assign status.div_done = (cnt == lvl);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvs         <= dvs_in;
      e_nonpos    <= e_max[EXT_W-1] || (e_max == '0);
      t_sh        <= {1'b0, e_max[COORD_BITS-1:0], 1'b0};
      k           <= KW'(1);
      best        <= '0;
      lim         <= lim_in;
      c2          <= c2_in;
      outside_acc <= 1'b0;
    end
    if (cmd.search) begin
      if (pass) begin
        best <= k;
        t_sh <= {t_sh[DV_W-1:0], 1'b0};
        k    <= KW'(k + KW'(1));
      end
    end
    if (cmd.set_level) begin
      lvl <= lvl_next;
    end
    if (cmd.div_init) begin
      neg  <= c2_sel[C2_W-1];
      over <= !c2_sel[C2_W-1] && (c2_sel >= $signed({2'b00, dvs}));
      rem  <= c2_sel[DV_W-1:0];
      q    <= '0;
      cnt  <= '0;
    end
    if (cmd.div_step) begin
      rem <= fit ? DV_W'(rem2 - {1'b0, dvs}) : rem2[DV_W-1:0];
      q   <= QW'({q, fit});
      cnt <= LW'(cnt + LW'(1));
    end
    if (cmd.store) begin
      if (neg)       cell_idx[cmd.axis] <= '0;
      else if (over) cell_idx[cmd.axis] <= CELL_W'(top);
      else           cell_idx[cmd.axis] <= CELL_W'(q);
      outside_acc <= outside_acc | neg | over;
    end
    if (cmd.commit) begin
      out_data.level   <= LEVEL_W'(lvl);
      out_data.cell_x  <= cell_idx[0];
      out_data.cell_y  <= cell_idx[1];
      out_data.cell_z  <= cell_idx[2];
      out_data.outside <= outside_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/lof_controller.sv */
// ----------------------------------------------------------------------------
// lof_controller: sequencer of the loose octree cell finder
// Steps one box through capture, level search, three divisions and
// hand-off to the result register.
// ----------------------------------------------------------------------------
module lof_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output lof_pkg::lof_cmd_t    cmd,
  input  lof_pkg::lof_status_t status
);
  import lof_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LEVEL,
    S_DIV_INIT,
    S_DIV,
    S_STORE,
    S_OUT
  } state_t;

  state_t     state;
  logic [1:0] axis;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.axis      = axis;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.search    = (state == S_SEARCH);
    cmd.set_level = (state == S_LEVEL);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV) && !status.div_done;
    cmd.store     = (state == S_STORE);
    cmd.commit    = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_X;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (status.search_last) state <= S_LEVEL;
        end
        S_LEVEL: begin
          axis  <= AXIS_X;
          state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_done) state <= S_STORE;
        end
        S_STORE: begin
          if (axis == AXIS_Z) begin
            state <= S_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_DIV_INIT;
          end
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/loose_octree_cell_finder.sv */
// ----------------------------------------------------------------------------
// loose_octree_cell_finder: insertion level and cell of a box in a loose octree
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one box (signed 16.8
//   corners). Each transfer yields exactly one result on out_valid/out_ready/
//   out_data: tree level, cell index per axis and the outside flag.
//   Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata, one
//   register per cycle, only while no box is in flight.
// Throughput:
//   One box at a time: it runs through the level test steps, then one
//   division per axis in turn; the shared restoring divider makes one
//   quotient bit per cycle per axis, as many bits as the chosen level.
//   The next box is taken in the cycle after the result loads.
// Stall:
//   The result register holds the last result while the receiver stalls;
//   the next box is taken and processed meanwhile and waits for the register.
// Reset:
//   rst (synchronous) idles the sequencer, drops out_valid and loads the
//   register defaults: cube corner 0, cube size 65536, max depth 8.
// ----------------------------------------------------------------------------
module loose_octree_cell_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lof_pkg::box_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lof_pkg::cell_t                    out_data,
  input  logic                              cfg_wr_en,
  input  logic [lof_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [lof_pkg::COORD_BITS-1:0]    cfg_wdata
);
  import lof_pkg::*;

  cfg_t        cfg;
  lof_cmd_t    cmd;
  lof_status_t status;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cube_low_x <= '0;
      cfg.cube_low_y <= '0;
      cfg.cube_low_z <= '0;
      cfg.cube_size  <= COORD_BITS'(65536);
      cfg.max_depth  <= DEPTH_W'(8);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_CUBE_LOW_X: cfg.cube_low_x <= cfg_wdata;
        REG_CUBE_LOW_Y: cfg.cube_low_y <= cfg_wdata;
        REG_CUBE_LOW_Z: cfg.cube_low_z <= cfg_wdata;
        REG_CUBE_SIZE:  cfg.cube_size  <= cfg_wdata;
        REG_MAX_DEPTH:  cfg.max_depth  <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: capture, search, divide each axis, hand off
  lof_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // arithmetic and result register
  lof_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a transfer in starts work: the sequencer is busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a box is in work");

  // the level never exceeds the depth limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.level) <= 32'(cfg.max_depth)))
    else $error("level above max_depth");

  // every cell index lies inside the grid of its level
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((32'(out_data.cell_x) | 32'(out_data.cell_y)
                     | 32'(out_data.cell_z)) >> out_data.level) == 0))
    else $error("cell index beyond grid");

endmodule

/* dv/loose_octree_cell_finder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loose_octree_cell_finder_test: self-checking bench of the octree cell finder
// Boxes are pushed through the valid/ready input channel, and each box gets a
// predicted level, cell and outside flag from a bench-side model of the
// level search and the per-axis division. Results are checked in order under
// several cube settings and under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module loose_octree_cell_finder_test;
  import lof_pkg::*;

  localparam int NUM_PHASES  = 14;
  localparam int BOXES_PER_PHASE = 122;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic   in_valid = 1'b0;
  logic   in_ready;
  box_t   in_data = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  cell_t  out_data;
  logic   cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_addr = '0;
  logic [COORD_BITS-1:0] cfg_wdata = '0;

  // bench copy of the configuration the block holds
  cfg_t cube_cfg = '{cube_low_x: '0, cube_low_y: '0, cube_low_z: '0,
                     cube_size: COORD_BITS'(65536), max_depth: DEPTH_W'(8)};

  box_t  pending_boxes [$];
  cell_t expected_cells [$];
  cell_t want_cell;

  int send_idle_pct = 0;
  int stall_pct = 0;
  logic receiver_hold = 1'b0;
  int error_count = 0;
  int result_count = 0;
  int unsigned cycle_count = 0;

  always #2 clk = ~clk;

  loose_octree_cell_finder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Level and cell of one box under the given cube settings.
  // The level test compares 2*size against extent*2^k so no half-units appear;
  // the cell uses twice the center offset divided by twice the size.
  function automatic cell_t predict_cell(input box_t b, input cfg_t c);
    longint lo [3];
    longint hi [3];
    longint base [3];
    longint span, size2, c2, quot, top;
    int best, lvl, lim;
    logic stop;
    cell_t r;
    logic [CELL_W-1:0] idx [3];
    logic out_flag;
    lo[0] = b.box_low_x;
    lo[1] = b.box_low_y;
    lo[2] = b.box_low_z;
    hi[0] = b.box_high_x;
    hi[1] = b.box_high_y;
    hi[2] = b.box_high_z;
    base[0] = c.cube_low_x;
    base[1] = c.cube_low_y;
    base[2] = c.cube_low_z;
    // a zero cube size counts as one unit
    size2 = 2 * ((c.cube_size == 0) ? longint'(1) : longint'(c.cube_size));
    span = hi[0] - lo[0];
    if (hi[1] - lo[1] > span) span = hi[1] - lo[1];
    if (hi[2] - lo[2] > span) span = hi[2] - lo[2];
    if (span <= 0) begin
      // empty or inverted box goes to the deepest level
      lvl = MAX_LEVELS;
    end else begin
      best = 0;
      stop = 1'b0;
      for (int k = 1; k <= MAX_LEVELS + 1; k++) begin
        if (!stop && size2 >= (span <<< k)) best = k;
        else stop = 1'b1;
      end
      // a box wider than the cube would want level -1: use the root
      lvl = (best > 0) ? best - 1 : 0;
      if (lvl > MAX_LEVELS) lvl = MAX_LEVELS;
    end
    lim = (c.max_depth > MAX_LEVELS) ? MAX_LEVELS : int'(c.max_depth);
    if (lvl > lim) lvl = lim;
    top = (longint'(1) <<< lvl) - 1;
    out_flag = 1'b0;
    for (int a = 0; a < 3; a++) begin
      c2 = lo[a] + hi[a] - 2 * base[a];
      if (c2 < 0) begin
        idx[a] = '0;
        out_flag = 1'b1;
      end else begin
        quot = (c2 <<< lvl) / size2;
        if (quot > top) begin
          idx[a] = CELL_W'(top);
          out_flag = 1'b1;
        end else begin
          idx[a] = CELL_W'(quot);
        end
      end
    end
    r.level   = LEVEL_W'(lvl);
    r.cell_x  = idx[0];
    r.cell_y  = idx[1];
    r.cell_z  = idx[2];
    r.outside = out_flag;
    return r;
  endfunction

  function automatic box_t box_of(input longint lx, input longint ly, input longint lz,
                                  input longint hx, input longint hy, input longint hz);
    box_t b;
    b.box_low_x  = COORD_BITS'(lx);
    b.box_low_y  = COORD_BITS'(ly);
    b.box_low_z  = COORD_BITS'(lz);
    b.box_high_x = COORD_BITS'(hx);
    b.box_high_y = COORD_BITS'(hy);
    b.box_high_z = COORD_BITS'(hz);
    return b;
  endfunction

  // Mostly well-formed boxes around the cube with a random size class, so
  // every level gets hit; some inverted, some empty, some pure noise.
  function automatic box_t rand_box(input cfg_t c);
    longint base [3];
    longint lo [3];
    longint hi [3];
    longint sz, ctr, half, tmp;
    int sh, kind;
    box_t b;
    sz = (c.cube_size == 0) ? longint'(1) : longint'(c.cube_size);
    base[0] = c.cube_low_x;
    base[1] = c.cube_low_y;
    base[2] = c.cube_low_z;
    kind = $urandom_range(99);
    sh = $urandom_range(0, 15);
    for (int a = 0; a < 3; a++) begin
      ctr = base[a] + longint'($urandom) % (sz + sz / 4 + 1) - sz / 8;
      half = longint'($urandom) % ((sz >>> sh) + 1);
      lo[a] = ctr - half;
      hi[a] = ctr + half + longint'($urandom_range(0, 1));
      if (kind < 8 && $urandom_range(0, 1) == 1) begin
        tmp = lo[a];
        lo[a] = hi[a];
        hi[a] = tmp;
      end
      if (kind >= 8 && kind < 12) hi[a] = lo[a];
    end
    b = box_of(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    if (kind >= 86) begin
      b.box_low_x  = COORD_BITS'($urandom);
      b.box_low_y  = COORD_BITS'($urandom);
      b.box_low_z  = COORD_BITS'($urandom);
      b.box_high_x = COORD_BITS'($urandom);
      b.box_high_y = COORD_BITS'($urandom);
      b.box_high_z = COORD_BITS'($urandom);
    end
    return b;
  endfunction

  // Append one box to the tail of the send queue.
  task automatic enqueue_box(input box_t b);
    pending_boxes = {pending_boxes, b};
  endtask

  // Boxes on the cube boundary: a point at the low corner, a unit-wide box
  // reaching just below it, and a unit-wide box at the top edge.
  task automatic queue_edge_boxes(input cfg_t c);
    longint sz;
    sz = (c.cube_size == 0) ? longint'(1) : longint'(c.cube_size);
    enqueue_box(box_of(c.cube_low_x, c.cube_low_y, c.cube_low_z,
                       c.cube_low_x, c.cube_low_y, c.cube_low_z));
    enqueue_box(box_of(c.cube_low_x - 1, c.cube_low_y, c.cube_low_z,
                       c.cube_low_x, c.cube_low_y, c.cube_low_z));
    enqueue_box(box_of(c.cube_low_x, c.cube_low_y + sz, c.cube_low_z + sz - 1,
                       c.cube_low_x, c.cube_low_y + sz, c.cube_low_z + sz));
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [COORD_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_CUBE_LOW_X, c.cube_low_x);
    write_reg(REG_CUBE_LOW_Y, c.cube_low_y);
    write_reg(REG_CUBE_LOW_Z, c.cube_low_z);
    write_reg(REG_CUBE_SIZE, c.cube_size);
    // only the low bits of the depth register exist; fill the rest with junk
    write_reg(REG_MAX_DEPTH, {(COORD_BITS-DEPTH_W)'($urandom), c.max_depth});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cube_cfg = c;
  endtask

  // Wait until every queued box has been transferred and answered.
  task automatic drain;
    do @(negedge clk);
    while (pending_boxes.size() != 0 || in_valid || expected_cells.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH result %0d: %s", result_count, msg);
    error_count++;
  endtask

  // Driver: record the prediction on each input transfer, then offer the
  // next box unless an idle cycle is drawn. Valid only drops when free.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_cells = {expected_cells, predict_cell(in_data, cube_cfg)};
      end
      if (!in_valid || in_ready) begin
        if (pending_boxes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_boxes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("result with no box pending: %p", out_data));
        end else begin
          want_cell = expected_cells.pop_front();
          if (out_data.level !== want_cell.level)
            report_mismatch($sformatf("level %0d, want %0d", out_data.level, want_cell.level));
          if (out_data.cell_x !== want_cell.cell_x)
            report_mismatch($sformatf("cell_x %0d, want %0d", out_data.cell_x,
                                      want_cell.cell_x));
          if (out_data.cell_y !== want_cell.cell_y)
            report_mismatch($sformatf("cell_y %0d, want %0d", out_data.cell_y,
                                      want_cell.cell_y));
          if (out_data.cell_z !== want_cell.cell_z)
            report_mismatch($sformatf("cell_z %0d, want %0d", out_data.cell_z,
                                      want_cell.cell_z));
          if (out_data.outside !== want_cell.outside)
            report_mismatch($sformatf("outside %0b, want %0b", out_data.outside,
                                      want_cell.outside));
        end
        result_count++;
      end
      out_ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    cfg_t next_cfg;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed boxes under the reset settings: size 65536, corner 0, depth 8.
    @(negedge clk);
    send_idle_pct = 0;
    stall_pct = 0;
    // empty box at the center, and an inverted one
    enqueue_box(box_of(32768, 32768, 32768, 32768, 32768, 32768));
    enqueue_box(box_of(40000, 100, 100, 30000, 100, 100));
    // wider than half the cube: root level
    enqueue_box(box_of(-3000, 0, 0, 67000, 10, 10));
    // extents right at and just past the level-one boundary
    enqueue_box(box_of(0, 0, 0, 32768, 100, 100));
    enqueue_box(box_of(0, 0, 0, 32769, 100, 100));
    // tiny box wants the deepest level, held back by the depth register
    enqueue_box(box_of(1000, 2000, 3000, 1001, 2000, 3000));
    // center below the cube on z, at the top edge on y
    enqueue_box(box_of(100, 65536, -5, 200, 65536, -5));
    // field extremes
    enqueue_box(box_of(-8388608, -8388608, -8388608,
                       -8388608, -8388608, -8388608));
    enqueue_box(box_of(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    enqueue_box(box_of(-8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607));
    enqueue_box(box_of(8388607, 8388607, 8388607,
                       -8388608, -8388608, -8388608));
    enqueue_box(box_of(-8388608, 0, 8388606, -8388607, 1, 8388607));
    queue_edge_boxes(cube_cfg);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: next_cfg = '{cube_low_x: '0, cube_low_y: '0, cube_low_z: '0,
                        cube_size: COORD_BITS'(65536), max_depth: DEPTH_W'(12)};
        1: next_cfg = '{cube_low_x: 24'h800000, cube_low_y: 24'h800000,
                        cube_low_z: 24'h800000, cube_size: 24'hFFFFFF,
                        max_depth: DEPTH_W'(12)};
        2: next_cfg = '{cube_low_x: 24'h7FFFFF, cube_low_y: 24'h7FFFFF,
                        cube_low_z: 24'h7FFFFF, cube_size: COORD_BITS'(1),
                        max_depth: DEPTH_W'(0)};
        3: next_cfg = '{cube_low_x: COORD_BITS'($urandom), cube_low_y: COORD_BITS'($urandom),
                        cube_low_z: COORD_BITS'($urandom), cube_size: '0,
                        max_depth: DEPTH_W'(15)};
        4: next_cfg = '{cube_low_x: -24'sd2048, cube_low_y: 24'sd1000, cube_low_z: '0,
                        cube_size: COORD_BITS'(4096), max_depth: DEPTH_W'(13)};
        5: next_cfg = '{cube_low_x: 24'h800000, cube_low_y: 24'h800000,
                        cube_low_z: 24'h800000, cube_size: 24'hFFFFFF,
                        max_depth: DEPTH_W'(8)};
        default: begin
          next_cfg.cube_low_x = COORD_BITS'($urandom);
          next_cfg.cube_low_y = COORD_BITS'($urandom);
          next_cfg.cube_low_z = COORD_BITS'($urandom);
          next_cfg.cube_size  = COORD_BITS'($urandom) >> $urandom_range(0, 20);
          next_cfg.max_depth  = DEPTH_W'($urandom_range(0, 15));
        end
      endcase
      write_config(next_cfg);

      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (p == 5) begin
        // Hold the receiver off while boxes keep coming, so the result
        // register fills and the input channel backs up.
        send_idle_pct = 0;
        stall_pct = 0;
        fork
          begin
            @(posedge clk);
            receiver_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            receiver_hold <= 1'b0;
          end
        join_none
      end
      queue_edge_boxes(cube_cfg);
      repeat (BOXES_PER_PHASE) enqueue_box(rand_box(cube_cfg));
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
